[rtl/stg_pkg.sv]
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, register indexes, defaults and the quarter-wave sine
// function used to load the sine table of the tone burst generator.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COUNT_BITS_DEF      = 24;
  localparam int PHASE_BITS_DEF      = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int TOTAL_BITS     = 32;
  localparam int AMP_BITS       = 16;
  localparam int OFFSET_BITS    = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BURST_MODE    = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_AMPLITUDE     = 3'd2,
    REG_DC_OFFSET     = 3'd3,
    REG_OFF_SAMPLES   = 3'd4,
    REG_ON_SAMPLES    = 3'd5,
    REG_TOTAL_SAMPLES = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic on;
    logic act;
  } ctl_t;

  typedef struct packed {
    logic saturated;
    logic active;
    logic burst_on;
  } flags_t;

  // Quarter-wave sine entry in Q(sbits-1), evaluated at elaboration only.
  function automatic longint quarter_sine(input int q, input int abits, input int sbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint smax;
    longint v;
    x    = (longint'(q) * 64'd1686629713) >> (abits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    smax = (longint'(1) << (sbits - 1)) - 1;
    v = (sum * smax + (longint'(1) << 29)) >>> 30;
    if (v > smax) begin
      v = smax;
    end
    return v;
  endfunction

endpackage

[rtl/sine_tone_burst_generator.sv]
// ----------------------------------------------------------------------------
// sine_tone_burst_generator
// Direct digital synthesis sine source with gated tone bursts.
// ----------------------------------------------------------------------------
// Each input transaction is one sample tick and yields exactly one output
// transaction, one per clock when both sides keep up, through the table read
// register, the amplitude product register and the output register. The sine
// table RAM serves one read per tick through its single read port. After reset the
// table is loaded from a constant quarter wave, one entry per cycle, covering all
// 2^TABLE_ADDR_BITS entries (1024 by default); s_tready stays low during
// that load while configuration writes are taken as usual.
module sine_tone_burst_generator
  import stg_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // [0] restart
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_BITS + 7) / 8)*8-1:0]  m_tdata,   // sample_value
  output logic [2:0]                            m_tuser,   // burst_on, active, saturated
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data
);

  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

  logic                          burst_mode;
  logic [PHASE_BITS-1:0]         phase_step;
  logic [AMP_BITS-1:0]           amplitude;
  logic signed [OFFSET_BITS-1:0] dc_offset;
  logic [COUNT_BITS-1:0]         off_samples;
  logic [COUNT_BITS-1:0]         on_samples;
  logic [TOTAL_BITS-1:0]         total_samples;

  logic                          fill_we;
  logic [TABLE_ADDR_BITS-1:0]    fill_addr;
  logic [SAMPLE_BITS-1:0]        fill_data;
  logic                          fill_done;

  logic                          advance;
  logic                          accept;
  logic [TABLE_ADDR_BITS-1:0]    rd_addr;
  logic [SAMPLE_BITS-1:0]        rd_data;
  ctl_t                          ctl;
  logic [SAMPLE_BITS-1:0]        out_sample;
  flags_t                        out_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_mode    <= 1'b0;
      phase_step    <= '0;
      amplitude     <= '0;
      dc_offset     <= '0;
      off_samples   <= '0;
      on_samples    <= '0;
      total_samples <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BURST_MODE:    burst_mode    <= cfg_data[0];
        REG_PHASE_STEP:    phase_step    <= PHASE_BITS'(cfg_data);
        REG_AMPLITUDE:     amplitude     <= cfg_data[AMP_BITS-1:0];
        REG_DC_OFFSET:     dc_offset     <= cfg_data[OFFSET_BITS-1:0];
        REG_OFF_SAMPLES:   off_samples   <= COUNT_BITS'(cfg_data[23:0]);
        REG_ON_SAMPLES:    on_samples    <= COUNT_BITS'(cfg_data[23:0]);
        REG_TOTAL_SAMPLES: total_samples <= cfg_data[TOTAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = fill_done && advance;
  assign accept   = s_tvalid && s_tready;

  stg_sine_fill #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_fill (
    .clk  (clk),
    .rst  (rst),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .done (fill_done)
  );

  stg_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(1 << TABLE_ADDR_BITS)
  ) u_sine_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  stg_ctrl #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .COUNT_BITS     (COUNT_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .restart      (s_tdata[0]),
    .burst_mode   (burst_mode),
    .phase_step   (phase_step),
    .off_samples  (off_samples),
    .on_samples   (on_samples),
    .total_samples(total_samples),
    .rd_addr      (rd_addr),
    .ctl          (ctl)
  );

  stg_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .accept    (accept),
    .ctl_in    (ctl),
    .rd_data   (rd_data),
    .amplitude (amplitude),
    .dc_offset (dc_offset),
    .out_valid (m_tvalid),
    .out_sample(out_sample),
    .out_flags (out_flags)
  );

  assign m_tdata = TDW'(out_sample);
  assign m_tuser = {out_flags.saturated, out_flags.active, out_flags.burst_on};

endmodule

[rtl/stg_ram.sv]
// ----------------------------------------------------------------------------
// stg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module stg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/stg_sine_fill.sv]
// ----------------------------------------------------------------------------
// stg_sine_fill
// Loads the full-wave sine table after reset, one entry per cycle, by
// folding a constant quarter-wave table.
// ----------------------------------------------------------------------------
module stg_sine_fill
  import stg_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       we,
  output logic [TABLE_ADDR_BITS-1:0] waddr,
  output logic [SAMPLE_BITS-1:0]     wdata,
  output logic                       done
);

  localparam int QSIZE = 1 << (TABLE_ADDR_BITS - 2);
  localparam int QIB   = TABLE_ADDR_BITS - 1;

  logic [SAMPLE_BITS-1:0]     qtab [QSIZE+1];
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]                 quad;
  logic [QIB-1:0]             q;
  logic [QIB-1:0]             qi;
  logic [SAMPLE_BITS-1:0]     s;

  for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
    assign qtab[g] = SAMPLE_BITS'(quarter_sine(g, TABLE_ADDR_BITS, SAMPLE_BITS));
  end

  assign quad  = addr[TABLE_ADDR_BITS-1 -: 2];
  assign q     = {1'b0, addr[TABLE_ADDR_BITS-3:0]};
  assign qi    = quad[0] ? (QIB'(QSIZE) - q) : q;
  assign s     = qtab[qi];
  assign wdata = quad[1] ? (-s) : s;
  assign we    = !done;
  assign waddr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      done <= 1'b0;
    end else if (!done) begin
      addr <= addr + 1'b1;
      if (&addr) begin
        done <= 1'b1;
      end
    end
  end

endmodule

[rtl/stg_ctrl.sv]
// ----------------------------------------------------------------------------
// stg_ctrl
// Phase accumulator, burst sequencer and sample counter. Issues the sine
// table read for each accepted tick.
// ----------------------------------------------------------------------------
module stg_ctrl
  import stg_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       restart,
  input  logic                       burst_mode,
  input  logic [PHASE_BITS-1:0]      phase_step,
  input  logic [COUNT_BITS-1:0]      off_samples,
  input  logic [COUNT_BITS-1:0]      on_samples,
  input  logic [TOTAL_BITS-1:0]      total_samples,
  output logic [TABLE_ADDR_BITS-1:0] rd_addr,
  output ctl_t                       ctl
);

  logic [PHASE_BITS-1:0] phase_acc, phase_acc_next;
  logic [COUNT_BITS-1:0] burst_count, burst_count_next;
  logic                  in_on_part, in_on_part_next;
  logic [TOTAL_BITS-1:0] sample_count, sample_count_next;

  always_comb begin
    logic [PHASE_BITS-1:0] pa;
    logic [COUNT_BITS-1:0] bc;
    logic                  ion;
    logic [TOTAL_BITS-1:0] sc;
    pa  = restart ? '0 : phase_acc;
    bc  = restart ? '0 : burst_count;
    ion = restart ? 1'b0 : in_on_part;
    sc  = restart ? '0 : sample_count;
    ctl.on  = 1'b0;
    ctl.act = 1'b0;
    phase_acc_next    = pa;
    burst_count_next  = bc;
    in_on_part_next   = ion;
    sample_count_next = sc;
    rd_addr = pa[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    if (sc < total_samples) begin
      ctl.act = 1'b1;
      sample_count_next = sc + 1'b1;
      if (!burst_mode) begin
        ctl.on = 1'b1;
        phase_acc_next = pa + phase_step;
      end else begin
        if (ion && bc >= on_samples) begin
          ion = 1'b0;
          bc  = '0;
        end
        if (!ion && bc >= off_samples) begin
          ion = 1'b1;
          bc  = '0;
          pa  = '0;
        end
        rd_addr = pa[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        phase_acc_next = pa;
        if (ion && bc >= on_samples) begin
          in_on_part_next  = 1'b0;
          burst_count_next = '0;
        end else if (ion) begin
          ctl.on = 1'b1;
          in_on_part_next  = 1'b1;
          burst_count_next = bc + 1'b1;
          phase_acc_next   = pa + phase_step;
        end else begin
          in_on_part_next  = 1'b0;
          burst_count_next = bc + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      burst_count  <= '0;
      in_on_part   <= 1'b0;
      sample_count <= '0;
    end else if (accept) begin
      phase_acc    <= phase_acc_next;
      burst_count  <= burst_count_next;
      in_on_part   <= in_on_part_next;
      sample_count <= sample_count_next;
    end
  end

endmodule

[rtl/stg_scale.sv]
// ----------------------------------------------------------------------------
// stg_scale
// Sample pipeline: table data, amplitude product, then rounding, offset and
// saturation into the output register. All stages advance together.
// ----------------------------------------------------------------------------
module stg_scale
  import stg_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          accept,
  input  ctl_t                          ctl_in,
  input  logic signed [SAMPLE_BITS-1:0] rd_data,
  input  logic [AMP_BITS-1:0]           amplitude,
  input  logic signed [OFFSET_BITS-1:0] dc_offset,
  output logic                          out_valid,
  output logic [SAMPLE_BITS-1:0]        out_sample,
  output flags_t                        out_flags
);

  localparam int PW = SAMPLE_BITS + AMP_BITS + 1;
  localparam int SW = ((SAMPLE_BITS > AMP_BITS + 1) ? SAMPLE_BITS : AMP_BITS + 1) + 2;
  localparam int HW = PW + 1 - SAMPLE_BITS;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic                 v1, v2;
  ctl_t                 c1, c2;
  logic signed [PW-1:0] prod;

  logic signed [PW:0]   rounded;
  logic signed [HW-1:0] shifted;
  logic signed [SW-1:0] total;
  logic                 sat;
  logic signed [SW-1:0] clipped;

  always_comb begin
    rounded = {prod[PW-1], prod} + ((PW + 1)'(1) <<< (SAMPLE_BITS - 1));
    shifted = rounded[PW -: HW];
    total   = {{(SW - HW){shifted[HW-1]}}, shifted}
            + {{(SW - OFFSET_BITS){dc_offset[OFFSET_BITS-1]}}, dc_offset};
    sat     = 1'b0;
    clipped = total;
    if (total > SMAX) begin
      clipped = SMAX;
      sat     = 1'b1;
    end else if (total < SMIN) begin
      clipped = SMIN;
      sat     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= accept;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1   <= ctl_in;
      c2   <= c1;
      prod <= $signed({1'b0, amplitude}) * rd_data;
      if (c2.on) begin
        out_sample <= clipped[SAMPLE_BITS-1:0];
      end else begin
        out_sample <= '0;
      end
      out_flags.burst_on  <= c2.on;
      out_flags.active    <= c2.act;
      out_flags.saturated <= c2.on & sat;
    end
  end

endmodule

[rtl/stg_checker.sv]
// ----------------------------------------------------------------------------
// stg_checker
// Port-level checks for the tone burst generator, bound to the top level.
// ----------------------------------------------------------------------------
module stg_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((SAMPLE_BITS + 7) / 8)*8-1:0] m_tdata,
  input logic [2:0]                           m_tuser
);

  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output transaction changed while stalled.");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[2])
    else $error("Sample outside the on part is not zero.");

  a_inactive_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> !m_tuser[0])
    else $error("Sine output while inactive.");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |->
      m_tdata[SAMPLE_BITS-1:0] == SMAX || m_tdata[SAMPLE_BITS-1:0] == SMIN)
    else $error("Saturation flag without a clipped sample.");

  a_load_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("Input taken before the sine table was loaded.");

endmodule

bind sine_tone_burst_generator stg_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_stg_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the sine tone burst generator. A clocked driver
// feeds sample ticks from a queue, a predictor computes the expected sample
// for every accepted tick, and a clocked monitor checks each output
// transaction against the oldest prediction. Directed ticks cover the field
// extremes and the burst corner cases, then randomized register settings
// and tick streams run under varying back pressure.
// ----------------------------------------------------------------------------
module tb_top
  import stg_pkg::*;
();

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 20;
  localparam int PHASE_TICKS = 50;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               saturated;
    logic               active;
    logic               burst_on;
  } sample_rec_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [15:0]               m_tdata;
  logic [2:0]                m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic               mode_burst  = 1'b0;
  logic [31:0]        step_reg    = '0;
  logic [15:0]        amp_reg     = '0;
  logic signed [15:0] offset_reg  = '0;
  logic [23:0]        off_len_reg = '0;
  logic [23:0]        on_len_reg  = '0;
  logic [31:0]        total_reg   = '0;

  logic [31:0] phase_acc  = '0;
  logic [23:0] burst_cnt  = '0;
  logic        on_part    = 1'b0;
  logic [31:0] sample_cnt = '0;

  int sine_lut [0:1023];

  logic        tick_queue [$];
  sample_rec_t expected_samples [$];
  int          ticks_pushed   = 0;
  int          ticks_accepted = 0;
  int          results_seen   = 0;
  int          error_count    = 0;
  int          idle_cycles    = 0;
  int          src_idle_pct   = 38;
  int          sink_idle_pct  = 86;
  logic        sink_hold      = 1'b0;
  logic        hold_go        = 1'b0;

  sine_tone_burst_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] restart
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [15:0] sample_value
    .m_tuser   (m_tuser),    // [0] burst_on, [1] active, [2] saturated
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Quarter wave in Q15 from a Q30 Taylor series of the angle q/256 * pi/2.
  function automatic int quarter_wave(input int q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          v;
    int              k;
    x    = (longint'(q) * 64'd1686629713) >> 8;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc * 32767 + (longint'(1) << 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return int'(v);
  endfunction

  function automatic sample_rec_t tone_sample();
    longint      prod;
    longint      v;
    sample_rec_t r;
    r          = '0;
    r.active   = 1'b1;
    r.burst_on = 1'b1;
    prod = longint'(amp_reg) * longint'(sine_lut[phase_acc[31:22]]);
    v    = ((prod + 64'sd32768) >>> 16) + longint'(offset_reg);
    if (v > 32767) begin
      v = 32767;
      r.saturated = 1'b1;
    end
    if (v < -32768) begin
      v = -32768;
      r.saturated = 1'b1;
    end
    r.sample  = v[15:0];
    phase_acc = phase_acc + step_reg;
    return r;
  endfunction

  function automatic sample_rec_t predict_sample(input logic restart);
    sample_rec_t r;
    r = '0;
    if (restart) begin
      phase_acc  = '0;
      burst_cnt  = '0;
      on_part    = 1'b0;
      sample_cnt = '0;
    end
    if (sample_cnt < total_reg) begin
      sample_cnt = sample_cnt + 32'd1;
      if (!mode_burst) begin
        r = tone_sample();
      end else begin
        if (on_part && burst_cnt >= on_len_reg) begin
          on_part   = 1'b0;
          burst_cnt = '0;
        end
        if (!on_part && burst_cnt >= off_len_reg) begin
          on_part   = 1'b1;
          burst_cnt = '0;
          phase_acc = '0;
        end
        if (on_part && burst_cnt >= on_len_reg) begin
          on_part   = 1'b0;
          burst_cnt = '0;
        end else if (on_part) begin
          r         = tone_sample();
          burst_cnt = burst_cnt + 24'd1;
        end else begin
          burst_cnt = burst_cnt + 24'd1;
        end
      end
      r.active = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint got, input longint want);
    error_count++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_samples.insert(expected_samples.size(), predict_sample(s_tdata[0]));
        ticks_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, tick_queue.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    sample_rec_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          note_mismatch("unexpected transaction", longint'($signed(m_tdata)), longint'(0));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want.sample) begin
            note_mismatch("sample_value", longint'($signed(m_tdata)), longint'(want.sample));
          end
          if (m_tuser[0] !== want.burst_on) begin
            note_mismatch("burst_on", longint'(m_tuser[0]), longint'(want.burst_on));
          end
          if (m_tuser[1] !== want.active) begin
            note_mismatch("active", longint'(m_tuser[1]), longint'(want.active));
          end
          if (m_tuser[2] !== want.saturated) begin
            note_mismatch("saturated", longint'(m_tuser[2]), longint'(want.saturated));
          end
        end
        results_seen++;
      end
      m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Stall the output long enough for the input side to back up.
  initial begin : sink_stall
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_BURST_MODE:    mode_burst  = val[0];
      REG_PHASE_STEP:    step_reg    = val;
      REG_AMPLITUDE:     amp_reg     = val[15:0];
      REG_DC_OFFSET:     offset_reg  = val[15:0];
      REG_OFF_SAMPLES:   off_len_reg = val[23:0];
      REG_ON_SAMPLES:    on_len_reg  = val[23:0];
      REG_TOTAL_SAMPLES: total_reg   = val;
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic restart);
    tick_queue.insert(tick_queue.size(), restart);
    ticks_pushed++;
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (ticks_accepted != ticks_pushed || expected_samples.size() != 0);
  endtask

  function automatic logic [31:0] pick_value(input int bits);
    logic [31:0] mask;
    int          r;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    r    = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return mask;
    end
    return $urandom & mask;
  endfunction

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0) begin
      return 32'h00FF_FFFF;
    end
    if (r == 1) begin
      return $urandom & 32'h00FF_FFFF;
    end
    return $urandom_range(8);
  endfunction

  function automatic logic [31:0] pick_total();
    int r;
    r = $urandom_range(7);
    if (r == 0) begin
      return 32'hFFFF_FFFF;
    end
    if (r == 1) begin
      return '0;
    end
    if (r < 4) begin
      return $urandom_range(60);
    end
    return $urandom_range(400, 60);
  endfunction

  function automatic logic [31:0] pick_offset();
    int r;
    r = $urandom_range(5);
    if (r == 0) begin
      return 32'h0000_8000;
    end
    if (r == 1) begin
      return 32'h0000_7FFF;
    end
    if (r == 2) begin
      return $urandom & 32'h0000_FFFF;
    end
    return (32'($urandom_range(4000)) - 32'd2000) & 32'h0000_FFFF;
  endfunction

  initial begin : stimulus
    int i;
    int ph;
    int n;
    for (i = 0; i < 1024; i++) begin
      if ((i / 256) % 2 == 1) begin
        sine_lut[i] = quarter_wave(256 - (i % 256));
      end else begin
        sine_lut[i] = quarter_wave(i % 256);
      end
      if ((i / 256) >= 2) begin
        sine_lut[i] = -sine_lut[i];
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset: zero length, so every tick is inactive.
    push_tick(1'b1);
    push_tick(1'b0);
    wait_drain();

    // Continuous quarter-turn steps with the largest offset clip the peaks.
    write_reg(REG_BURST_MODE, 32'd0);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_FFFF);
    write_reg(REG_DC_OFFSET, 32'h0000_7FFF);
    write_reg(REG_OFF_SAMPLES, 32'd2);
    write_reg(REG_ON_SAMPLES, 32'd3);
    write_reg(REG_TOTAL_SAMPLES, 32'd6);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();

    // Most negative offset clips the trough, then the length runs out.
    write_reg(REG_DC_OFFSET, 32'h0000_8000);
    write_reg(REG_PHASE_STEP, 32'hC000_0000);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();

    // Tone bursts: two off ticks, three on ticks, phase restarting per burst.
    write_reg(REG_BURST_MODE, 32'd1);
    write_reg(REG_PHASE_STEP, 32'h1000_0000);
    write_reg(REG_AMPLITUDE, 32'd30000);
    write_reg(REG_DC_OFFSET, 32'd100);
    write_reg(REG_TOTAL_SAMPLES, 32'd40);
    push_tick(1'b1);
    for (i = 0; i < 7; i++) begin
      push_tick(1'b0);
    end
    wait_drain();

    // Shorter lengths in the middle of a burst, then no off part at all.
    write_reg(REG_ON_SAMPLES, 32'd1);
    write_reg(REG_OFF_SAMPLES, 32'd0);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();

    // No on part: every tick stays in the off part.
    write_reg(REG_ON_SAMPLES, 32'd0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();

    // Back to continuous without a restart, then bursts again.
    write_reg(REG_BURST_MODE, 32'd0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();
    write_reg(REG_ON_SAMPLES, 32'd2);
    write_reg(REG_BURST_MODE, 32'd1);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        src_idle_pct  <= 86;
        sink_idle_pct <= 38;
      end else if (ph == (2 * PHASES) / 3) begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end
      write_reg(REG_BURST_MODE, $urandom_range(1));
      write_reg(REG_PHASE_STEP, pick_value(32));
      write_reg(REG_AMPLITUDE, pick_value(16));
      write_reg(REG_DC_OFFSET, pick_offset());
      write_reg(REG_OFF_SAMPLES, pick_length());
      write_reg(REG_ON_SAMPLES, pick_length());
      write_reg(REG_TOTAL_SAMPLES, pick_total());
      n = PHASE_TICKS;
      push_tick(1'($urandom_range(1)));
      for (i = 1; i < n; i++) begin
        push_tick($urandom_range(24) == 0);
      end
      if (ph == 3) begin
        hold_go = 1'b1;
      end
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (expected_samples.size() != 0) begin
      note_mismatch("missing transactions", longint'(0), longint'(expected_samples.size()));
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
